// ===== design/mf3_pkg.sv =====
// Package for the 3x3 mean filter stream block.
// Holds widths, reset values, register codes, payload types and the mean divider.
// No dependencies.
package mf3_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int POS_W = 10;
  localparam int SUM_W = 12;
  localparam int RECIP_W = 14;
  localparam int RECIP_SHIFT = 16;

  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 1024;
  localparam int MIN_SIZE = 2;

  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  // Reciprocals scaled by 2^16 and rounded up; exact for every sum below 32768.
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(10923);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean_out;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;
  } result_t;

  typedef struct packed {
    logic row_ge1;
    logic col_ge1;
    logic top_in;
    logic left_in;
    logic last_col;
    logic last_row;
  } mf3_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] two_above;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    mf3_flags_t       flags;
  } mf3_item_t;

  // Truncated mean of a window sum over 2 or 3 rows by 2 or 3 columns.
  function automatic logic [PIX_W-1:0] mean_div(input logic [SUM_W-1:0] sum,
                                                input logic three_rows,
                                                input logic three_cols);
    logic [RECIP_W-1:0]       recip;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [PIX_W-1:0]         q;
    recip = (three_rows && three_cols) ? RECIP_9 : RECIP_6;
    prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(recip);
    if (!three_rows && !three_cols) begin
      q = sum[PIX_W+1:2];
    end else begin
      q = prod[RECIP_SHIFT +: PIX_W];
    end
    return q;
  endfunction

endpackage

// ===== design/mf3_stream_if.sv =====
// Valid/ready stream interface used for the pixel input and the result output.
// The payload type is given at instantiation; no other dependencies.
interface mf3_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/mf3_front.sv =====
// Input stage of the 3x3 mean filter: size registers, row and column counters,
// the two line buffers (one memory) and the input register. Uses mf3_pkg, mf3_stream_if.
module mf3_front #(
  parameter int MAX_WIDTH = mf3_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  mf3_pkg::reg_index_t       cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0] cfg_data,
  mf3_stream_if.sink                pixel_stream,
  output mf3_pkg::mf3_item_t        item,
  output logic                      item_valid,
  input  logic                      item_take
);
  import mf3_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CNT_MAX_W = (AW > RW) ? AW : RW;
  localparam int LW = (CNT_MAX_W + 1 > CFG_W) ? CNT_MAX_W + 1 : CFG_W;

  logic [CFG_W-1:0]   image_width;
  logic [CFG_W-1:0]   image_height;
  logic [AW-1:0]      col_count;
  logic [RW-1:0]      row_count;

  logic [LW-1:0]      w_ext, h_ext, w_eff, h_eff;
  logic [LW-1:0]      col_inc, row_inc;
  logic               last_col, last_row;
  logic               accept;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_pixel;
  logic [POS_W-1:0]   s1_row;
  logic [POS_W-1:0]   s1_col;
  mf3_flags_t         s1_flags;
  logic [AW-1:0]      s1_addr;

  // Each entry holds {two rows above, one row above} for one column.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
      endcase
    end
  end

  always_comb begin
    w_ext = LW'(image_width);
    h_ext = LW'(image_height);
    if (w_ext < LW'(MIN_SIZE)) begin
      w_eff = LW'(MIN_SIZE);
    end else if (w_ext > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < LW'(MIN_SIZE)) begin
      h_eff = LW'(MIN_SIZE);
    end else if (h_ext > LW'(MAX_HEIGHT)) begin
      h_eff = LW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    col_inc = LW'(col_count) + LW'(1);
    row_inc = LW'(row_count) + LW'(1);
    // A counter at or beyond the last position after a size change ends the row at once.
    last_col = (col_inc >= w_eff);
    last_row = (row_inc >= h_eff);
  end

  assign pixel_stream.ready = !s1_valid || item_take;
  assign accept = pixel_stream.valid && pixel_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_inc[RW-1:0];
        end else begin
          col_count <= col_inc[AW-1:0];
        end
      end else if (item_take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel_stream.payload.pixel_in;
      s1_row <= POS_W'(row_count);
      s1_col <= POS_W'(col_count);
      s1_addr <= col_count;
      s1_flags.row_ge1 <= (row_count != '0);
      s1_flags.col_ge1 <= (col_count != '0);
      s1_flags.top_in <= (LW'(row_count) >= LW'(MIN_SIZE));
      s1_flags.left_in <= (LW'(col_count) >= LW'(MIN_SIZE));
      s1_flags.last_col <= last_col;
      s1_flags.last_row <= last_row;
    end
  end

  // The read is issued at the transfer; the column moves down one line when the
  // item leaves this stage, well before the next row reads the same column.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[col_count];
    end
    if (item_take) begin
      line_mem[s1_addr] <= {line_rd[PIX_W-1:0], s1_pixel};
    end
  end

  assign item_valid = s1_valid;

  always_comb begin
    item.pixel = s1_pixel;
    item.above = line_rd[PIX_W-1:0];
    item.two_above = line_rd[2*PIX_W-1:PIX_W];
    item.row = s1_row;
    item.col = s1_col;
    item.flags = s1_flags;
  end

endmodule

// ===== design/mf3_window.sv =====
// Window and result stage of the 3x3 mean filter: the 3x3 window registers,
// the four window means and the result register drained one transfer at a time.
// Uses mf3_pkg and mf3_stream_if.
module mf3_window (
  input  logic               clk,
  input  logic               rst,
  input  mf3_pkg::mf3_item_t item,
  input  logic               item_valid,
  output logic               item_take,
  mf3_stream_if.source       result_stream
);
  import mf3_pkg::*;

  logic [PIX_W-1:0] win [3][3];
  logic [PIX_W-1:0] win_next [3][3];
  logic [PIX_W+1:0] col_full [3];
  logic [PIX_W+1:0] col_bot [3];
  logic [SUM_W-1:0] sum_full_all, sum_full_right, sum_bot_all, sum_bot_right;

  result_t          res [4];
  result_t          res_next [4];
  logic [3:0]       pend;
  logic [3:0]       pend_new;
  logic [1:0]       sel;
  logic             fire;
  logic             last_one;
  logic             can_load;
  logic [POS_W-1:0] row_up, col_left;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      win_next[a][0] = win[a][1];
      win_next[a][1] = win[a][2];
    end
    win_next[0][2] = item.two_above;
    win_next[1][2] = item.above;
    win_next[2][2] = item.pixel;

    for (int b = 0; b < 3; b++) begin
      col_bot[b] = (PIX_W+2)'(win_next[1][b]) + (PIX_W+2)'(win_next[2][b]);
      col_full[b] = col_bot[b] + (item.flags.top_in ? (PIX_W+2)'(win_next[0][b]) : '0);
    end

    sum_full_right = SUM_W'(col_full[1]) + SUM_W'(col_full[2]);
    sum_full_all = sum_full_right + (item.flags.left_in ? SUM_W'(col_full[0]) : '0);
    sum_bot_right = SUM_W'(col_bot[1]) + SUM_W'(col_bot[2]);
    sum_bot_all = sum_bot_right + (item.flags.left_in ? SUM_W'(col_bot[0]) : '0);

    row_up = item.row - POS_W'(1);
    col_left = item.col - POS_W'(1);

    // Result for the pixel up and to the left, then the right edge, then the bottom row.
    res_next[0] = '{mean_out: mean_div(sum_full_all, item.flags.top_in, item.flags.left_in),
                    out_row: row_up, out_col: col_left, frame_last: 1'b0};
    res_next[1] = '{mean_out: mean_div(sum_full_right, item.flags.top_in, 1'b0),
                    out_row: row_up, out_col: item.col, frame_last: 1'b0};
    res_next[2] = '{mean_out: mean_div(sum_bot_all, 1'b0, item.flags.left_in),
                    out_row: item.row, out_col: col_left, frame_last: 1'b0};
    res_next[3] = '{mean_out: mean_div(sum_bot_right, 1'b0, 1'b0),
                    out_row: item.row, out_col: item.col, frame_last: 1'b1};

    pend_new[0] = item.flags.row_ge1 && item.flags.col_ge1;
    pend_new[1] = item.flags.row_ge1 && item.flags.last_col;
    pend_new[2] = item.flags.row_ge1 && item.flags.last_row && item.flags.col_ge1;
    pend_new[3] = item.flags.row_ge1 && item.flags.last_row && item.flags.last_col;
  end

  always_comb begin
    sel = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (pend[k]) begin
        sel = 2'(k);
      end
    end
  end

  assign result_stream.valid = |pend;
  assign result_stream.payload = res[sel];
  assign fire = result_stream.valid && result_stream.ready;
  assign last_one = ((pend & (pend - 4'd1)) == 4'd0);
  assign can_load = (pend == 4'd0) || (fire && last_one);
  assign item_take = item_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          win[a][b] <= '0;
        end
      end
    end else if (item_take) begin
      pend <= pend_new;
      win <= win_next;
    end else if (fire) begin
      // Each transfer retires the lowest pending result.
      pend <= pend & (pend - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res <= res_next;
    end
  end

endmodule

// ===== design/mean_filter_3x3_stream.sv =====
// 3x3 mean filter over a raster stream of 8-bit gray pixels.
// A result is offered from the result register once its pixel has passed the input
// register. Throughput: one pixel per cycle while the result port keeps up; a pixel that
// completes k results (up to four at the right edge and on the last row) holds the input
// until the single port has sent them. Reset (rst, synchronous) clears counters, window,
// pending results and restores the size registers; the line buffer memory is not cleared.
module mean_filter_3x3_stream #(
  parameter int MAX_WIDTH = mf3_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  mf3_pkg::reg_index_t       cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0] cfg_data,
  mf3_stream_if.sink                pixel_stream,
  mf3_stream_if.source              result_stream
);
  import mf3_pkg::*;

  mf3_item_t item;
  logic      item_valid;
  logic      item_take;

  mf3_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_stream(pixel_stream),
    .item(item),
    .item_valid(item_valid),
    .item_take(item_take)
  );

  mf3_window u_window (
    .clk(clk),
    .rst(rst),
    .item(item),
    .item_valid(item_valid),
    .item_take(item_take),
    .result_stream(result_stream)
  );

endmodule

// ===== design/mf3_checker.sv =====
// Port-level checks for the 3x3 mean filter, attached to the top level by bind.
// Uses mf3_pkg for the result payload type.
module mf3_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input mf3_pkg::result_t  out_payload
);
  import mf3_pkg::*;

  // Nothing is offered in the cycle after a reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed or dropped");

  // The input is only held back while a result waits for its transfer.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // The first row of a frame completes no result, so the frame end is followed by a gap.
  a_frame_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_payload.frame_last |=> !out_valid)
    else $error("result offered directly after the end of a frame");

endmodule

bind mean_filter_3x3_stream mf3_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(pixel_stream.ready),
  .out_valid(result_stream.valid),
  .out_ready(result_stream.ready),
  .out_payload(result_stream.payload)
);
